>>> rtl/core/frame_bitmap_allocator_macros.svh
// ---------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked only while out of reset.
`define FBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame bitmap allocator assertion failed");
// Next-cycle implication, checked only while out of reset.
`define FBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame bitmap allocator assertion failed");
`else
`define FBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/fba_pkg.sv
// ---------------------------------------------------------------------------
// Frame bitmap allocator package
// Sizes, action and status codes, and the bitmap memory request type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

  localparam int MAX_FRAMES  = 4096;
  localparam int WORD_BITS   = 32;
  localparam int WORD_COUNT  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_SHIFT = 12;
  localparam int ADDR_W      = 32;
  localparam int FRAME_W     = $clog2(MAX_FRAMES);
  localparam int WORD_AW     = $clog2(WORD_COUNT);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WCNT_W      = $clog2(WORD_COUNT + 1);
  localparam int CFG_W       = 13;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);
  localparam logic [CFG_W-1:0] CFG_MAX   = CFG_W'(MAX_FRAMES);

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_MARK    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_TEST    = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    word_t              wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [1:0]         status;
    logic               frame_used;
  } result_t;

  // Position of the lowest clear bit; only meaningful when one exists.
  function automatic logic [BIT_W-1:0] first_zero(input word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/frame_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// Frame bitmap allocator
// First-fit physical frame allocator over a one-bit-per-frame bitmap.
// ---------------------------------------------------------------------------
// Usage: each input transaction carries an action (allocate, mark used,
// release, test) and a page byte address; each one yields exactly one
// output transaction with the frame index, a status and the used flag.
// The frame count register is written through cfg_wr_en and cfg_wr_data,
// only while the block is idle, a rule for the user that the block does
// not enforce; it limits how many whole bitmap words allocate searches.
// Mark and release take one memory read-modify-write and test one read;
// the result then loads into the output register. Allocate reads one
// bitmap word per cycle from the lowest word up, searching at most the
// managed words (128 at the full frame count), and reports no free frame
// without any read when no whole word is managed. The single read port of
// the bitmap RAM sets this rate. The next transaction can be accepted in
// the cycle after the result loads.
// Only one transaction is in flight; in_stall stays high until its result
// has moved into the output register, which may still be waiting on the
// receiver while the next transaction is accepted.
// Reset clears the whole bitmap at once through per-word valid bits, so
// no clearing pass is needed, and restores the frame count to 4096.
// When out_stall is high, the output transaction holds and the block
// stops after finishing at most one more transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frame_bitmap_allocator_macros.svh"

module frame_bitmap_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_action,
  input  wire logic [fba_pkg::ADDR_W-1:0]  in_page_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [fba_pkg::FRAME_W-1:0]      out_frame_index,
  output logic [1:0]                       out_status,
  output logic                             out_frame_used,
  input  wire logic                        cfg_wr_en,
  input  wire logic [fba_pkg::CFG_W-1:0]   cfg_wr_data
);

  logic [fba_pkg::CFG_W-1:0] frames_in_use_r;
  logic                      req_ready;
  fba_pkg::mem_req_t         mreq;
  fba_pkg::word_t            rd_data;
  logic                      res_valid;
  logic                      res_take;
  fba_pkg::result_t          res;
  logic                      out_valid_r;
  fba_pkg::result_t          out_r;

  // Frame count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= fba_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use_r <= cfg_wr_data;
    end
  end

  // Nothing is taken while reset is held.
  assign in_stall = !req_ready || !rst_n;

  fba_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (in_valid && rst_n),
    .req_ready     (req_ready),
    .req_action    (in_action),
    .req_address   (in_page_address),
    .frames_in_use (frames_in_use_r),
    .mreq          (mreq),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  fba_bitmap_ram #(
    .DEPTH (fba_pkg::WORD_COUNT),
    .WIDTH (fba_pkg::WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mreq.rd_en),
    .rd_addr (mreq.rd_addr),
    .rd_data (rd_data),
    .wr_en   (mreq.wr_en),
    .wr_addr (mreq.wr_addr),
    .wr_data (mreq.wr_data)
  );

  // Output register: loads when empty or when its transaction drains.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_r.frame_index;
  assign out_status      = out_r.status;
  assign out_frame_used  = out_r.frame_used;

  // An accepted request always keeps the input side busy the next cycle.
  `FBA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // The bitmap is only written while a request is being worked on.
  `FBA_ASSERT_IMP(a_write_while_busy, clk, rst_n, mreq.wr_en, in_stall)
  // A failed allocate or range error reports frame zero.
  `FBA_ASSERT_IMP(a_fail_index_zero, clk, rst_n,
    out_valid && (out_status != fba_pkg::STAT_OK), out_frame_index == '0)
  // The used flag only appears on a successful request.
  `FBA_ASSERT_IMP(a_used_only_ok, clk, rst_n,
    out_valid && out_frame_used, out_status == fba_pkg::STAT_OK)

endmodule

`default_nettype wire

>>> rtl/core/fba_bitmap_ram.sv
// ---------------------------------------------------------------------------
// Frame bitmap RAM
// Synchronous one-read one-write memory with per-entry valid bits so that
// entries never written since reset read as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_bitmap_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_word_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

`default_nettype wire

>>> rtl/core/fba_ctrl.sv
// ---------------------------------------------------------------------------
// Frame bitmap allocator controller
// Sequencer for the read-modify-write and first-fit scan of the bitmap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic [1:0]                 req_action,
  input  wire logic [fba_pkg::ADDR_W-1:0] req_address,
  input  wire logic [fba_pkg::CFG_W-1:0]  frames_in_use,
  output fba_pkg::mem_req_t               mreq,
  input  wire fba_pkg::word_t             rd_data,
  output logic                            res_valid,
  input  wire logic                       res_take,
  output fba_pkg::result_t                res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RMW  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [1:0]                     act_r, act_nxt;
  logic [fba_pkg::WORD_AW-1:0]    word_r, word_nxt;
  logic [fba_pkg::BIT_W-1:0]      bit_r, bit_nxt;
  logic [fba_pkg::WCNT_W-1:0]     words_r, words_nxt;
  fba_pkg::result_t               res_r, res_nxt;

  logic [fba_pkg::WCNT_W-1:0]     words_cfg;
  logic                           out_of_range;
  logic [fba_pkg::FRAME_W-1:0]    req_frame;
  logic [fba_pkg::BIT_W-1:0]      zero_pos;
  fba_pkg::word_t                 bit_mask;

  assign req_frame    = req_address[fba_pkg::FRAME_SHIFT +: fba_pkg::FRAME_W];
  assign out_of_range = |req_address[fba_pkg::ADDR_W-1:fba_pkg::FRAME_SHIFT+fba_pkg::FRAME_W];
  assign words_cfg    = (frames_in_use > fba_pkg::CFG_MAX)
                        ? fba_pkg::WCNT_W'(fba_pkg::WORD_COUNT)
                        : fba_pkg::WCNT_W'(frames_in_use >> fba_pkg::BIT_W);
  assign zero_pos     = fba_pkg::first_zero(rd_data);
  assign bit_mask     = fba_pkg::word_t'(1) << bit_r;

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    word_nxt  = word_r;
    bit_nxt   = bit_r;
    words_nxt = words_r;
    res_nxt   = res_r;
    mreq      = '0;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          act_nxt   = req_action;
          words_nxt = words_cfg;
          res_nxt   = '0;
          if (req_action == fba_pkg::ACT_ALLOC) begin
            word_nxt = '0;
            if (words_cfg == '0) begin
              res_nxt.status = fba_pkg::STAT_NO_FREE;
              state_nxt      = ST_DONE;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = '0;
              state_nxt    = ST_SCAN;
            end
          end else if (out_of_range) begin
            res_nxt.status = fba_pkg::STAT_RANGE;
            state_nxt      = ST_DONE;
          end else begin
            word_nxt            = req_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
            bit_nxt             = req_frame[fba_pkg::BIT_W-1:0];
            res_nxt.frame_index = req_frame;
            mreq.rd_en          = 1'b1;
            mreq.rd_addr        = req_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
            state_nxt           = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        mreq.wr_addr = word_r;
        case (act_r)
          fba_pkg::ACT_MARK: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_data = rd_data | bit_mask;
          end
          fba_pkg::ACT_RELEASE: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_data = rd_data & ~bit_mask;
          end
          default: begin
            res_nxt.frame_used = |(rd_data & bit_mask);
          end
        endcase
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        // Read of the following word is issued while this one is checked.
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = word_r + 1'b1;
        if (~&rd_data) begin
          mreq.wr_en          = 1'b1;
          mreq.wr_addr        = word_r;
          mreq.wr_data        = rd_data | (fba_pkg::word_t'(1) << zero_pos);
          res_nxt.frame_index = {word_r, zero_pos};
          state_nxt           = ST_DONE;
        end else if ({1'b0, word_r} + 1'b1 == words_r) begin
          res_nxt.status = fba_pkg::STAT_NO_FREE;
          state_nxt      = ST_DONE;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    word_r  <= word_nxt;
    bit_r   <= bit_nxt;
    words_r <= words_nxt;
    res_r   <= res_nxt;
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire
